// ===== design/adsr_pkg.sv =====
`default_nettype none

package adsr_pkg;

  // Field and counter widths.
  localparam int TICK_BITS      = 24;
  localparam int SAMPLE_BITS    = 16;
  localparam int AGE_BITS       = TICK_BITS + 1;
  localparam int FRAC_BITS      = 16;
  localparam int LEVEL_BITS     = FRAC_BITS + 1;
  localparam int MUL_B_BITS     = (AGE_BITS > SAMPLE_BITS) ? AGE_BITS : SAMPLE_BITS;
  localparam int PROD_BITS      = LEVEL_BITS + MUL_B_BITS;
  localparam int QUO_BITS       = LEVEL_BITS;
  localparam int REM_BITS       = TICK_BITS + 1;
  localparam int CNT_BITS       = $clog2(QUO_BITS + 1);
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = (TICK_BITS > LEVEL_BITS) ? TICK_BITS : LEVEL_BITS;

  localparam logic [LEVEL_BITS-1:0] UNITY = LEVEL_BITS'(1 << FRAC_BITS);

  localparam logic [TICK_BITS-1:0]  ATTACK_RESET  = TICK_BITS'(4800);
  localparam logic [TICK_BITS-1:0]  DECAY_RESET   = TICK_BITS'(24000);
  localparam logic [LEVEL_BITS-1:0] SUSTAIN_RESET = LEVEL_BITS'(39322);
  localparam logic [TICK_BITS-1:0]  RELEASE_RESET = TICK_BITS'(4800);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } reg_index_t;

  // Register values as the datapath sees them; sustain is already limited to unity.
  typedef struct packed {
    logic [TICK_BITS-1:0]  atk_ticks;
    logic [TICK_BITS-1:0]  dec_ticks;
    logic [LEVEL_BITS-1:0] sus_level;
    logic [TICK_BITS-1:0]  rel_ticks;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== design/adsr_in_if.sv =====
`default_nettype none

interface adsr_in_if;
  import adsr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          start_note;
  logic                          note_off;

  modport source (output valid, output sample_in, output start_note, output note_off,
                  input ready);
  modport sink (input valid, input sample_in, input start_note, input note_off,
                output ready);
endinterface

`default_nettype wire

// ===== design/adsr_out_if.sv =====
`default_nettype none

interface adsr_out_if;
  import adsr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          alive;

  modport source (output valid, output sample_out, output alive, input ready);
  modport sink (input valid, input sample_out, input alive, output ready);
endinterface

`default_nettype wire

// ===== design/adsr_cfg.sv =====
`default_nettype none

module adsr_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [adsr_pkg::CFG_INDEX_BITS-1:0]  index,
  input  wire logic [adsr_pkg::CFG_DATA_BITS-1:0]   data,
  output adsr_pkg::cfg_t                            cfg
);
  import adsr_pkg::*;

  logic [TICK_BITS-1:0]  atk_ticks;
  logic [TICK_BITS-1:0]  dec_ticks;
  logic [LEVEL_BITS-1:0] sus_raw;
  logic [TICK_BITS-1:0]  rel_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      atk_ticks <= ATTACK_RESET;
      dec_ticks <= DECAY_RESET;
      sus_raw   <= SUSTAIN_RESET;
      rel_ticks <= RELEASE_RESET;
    end else if (wr_en) begin
      unique case (reg_index_t'(index))
        REG_ATTACK:  atk_ticks <= data[TICK_BITS-1:0];
        REG_DECAY:   dec_ticks <= data[TICK_BITS-1:0];
        REG_SUSTAIN: sus_raw   <= data[LEVEL_BITS-1:0];
        REG_RELEASE: rel_ticks <= data[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A sustain level above unity behaves as unity.
  always_comb begin
    cfg.atk_ticks = atk_ticks;
    cfg.dec_ticks = dec_ticks;
    cfg.sus_level = (sus_raw > UNITY) ? UNITY : sus_raw;
    cfg.rel_ticks = rel_ticks;
  end

endmodule

`default_nettype wire

// ===== design/adsr_mul.sv =====
`default_nettype none

module adsr_mul (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic [adsr_pkg::LEVEL_BITS-1:0]  a,
  input  wire logic [adsr_pkg::MUL_B_BITS-1:0]  b,
  output logic      [adsr_pkg::PROD_BITS-1:0]   prod
);
  import adsr_pkg::*;

  // The product holds while en is low, so later states may read it at leisure.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

`default_nettype wire

// ===== design/adsr_div.sv =====
`default_nettype none

module adsr_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [adsr_pkg::PROD_BITS-1:0]   dividend,
  input  wire logic [adsr_pkg::TICK_BITS-1:0]   divisor,
  output logic      [adsr_pkg::QUO_BITS-1:0]    quotient,
  output adsr_pkg::div_stat_t                   stat
);
  import adsr_pkg::*;

  logic [REM_BITS-1:0]  rem;
  logic [QUO_BITS-1:0]  lo;
  logic [CNT_BITS-1:0]  count;
  logic                 busy;
  logic                 done;
  logic [REM_BITS-1:0]  trial;
  logic [REM_BITS:0]    diff;
  logic                 fits;

  // Restoring division, one quotient bit a cycle. The caller guarantees the quotient
  // fits in QUO_BITS, so the upper dividend bits start out below the divisor.
  assign trial = {rem[REM_BITS-2:0], lo[QUO_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};
  assign fits  = ~diff[REM_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= REM_BITS'(dividend >> QUO_BITS);
        lo    <= dividend[QUO_BITS-1:0];
        count <= CNT_BITS'(QUO_BITS);
        busy  <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= diff[REM_BITS-1:0];
        end else begin
          rem <= trial;
        end
        lo    <= {lo[QUO_BITS-2:0], fits};
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = lo;
  assign stat.busy = busy;
  assign stat.done = done;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider finished without running");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider did not start");

  a_busy_counts: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != '0))
    else $error("divider running with no bits left");

endmodule

`default_nettype wire

// ===== design/adsr_envelope_generator_core.sv =====
`default_nettype none

// Linear ADSR envelope that scales one signed audio sample per request on the dry channel
// and returns the shaped sample with an alive flag on the wet channel. While a note is
// held, the level ramps up over attack_ticks, down to sustain_level over decay_ticks and
// then holds; with note_off set, the level reached last fades to zero over release_ticks,
// after which the output is zero and alive is low. A sample on an attack, decay or release
// ramp passes the planning, divider-start, serial-divide and final states, the divider
// forming each ramp step; a sample at sustain or after the release has ended skips the
// divider states. One request is in work at a time and dry.ready is high only while idle,
// but the result sits in an output register, so a new request may be accepted while the
// previous result still waits on wet. Configuration writes must be made while idle.

module adsr_envelope_generator_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [adsr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [adsr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  adsr_in_if.sink                                   dry,
  adsr_out_if.source                                wet
);
  import adsr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PLAN   = 5'b00010,
    ST_DSTART = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  localparam int RES_BITS = PROD_BITS - FRAC_BITS;
  localparam logic [RES_BITS-1:0]  POS_LIM   = RES_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [RES_BITS-1:0]  NEG_LIM   = RES_BITS'(1 << (SAMPLE_BITS - 1));
  localparam logic [PROD_BITS-1:0] ROUND_ADD = PROD_BITS'((1 << FRAC_BITS) - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  cfg_t                           cfg;
  state_t                         state;
  phase_t                         phase;

  // Envelope state.
  logic [AGE_BITS-1:0]            note_age;
  logic [AGE_BITS-1:0]            fade_age;
  logic [LEVEL_BITS-1:0]          env_level;

  // The request in work.
  logic signed [SAMPLE_BITS-1:0]  smp;
  logic                           req_off;
  logic                           res_zero;

  // Output register.
  logic                           wet_valid;
  logic signed [SAMPLE_BITS-1:0]  wet_sample;
  logic                           wet_alive;

  // Shared multiplier and divider.
  logic                           mul_en;
  logic [LEVEL_BITS-1:0]          mul_a;
  logic [MUL_B_BITS-1:0]          mul_b;
  logic [PROD_BITS-1:0]           mul_prod;
  logic                           div_start;
  logic [TICK_BITS-1:0]           divisor;
  logic [QUO_BITS-1:0]            quotient;
  div_stat_t                      div_stat;

  // Decisions taken in the planning state.
  logic [AGE_BITS-1:0]            rel_inc;
  logic                           rel_done;
  logic [AGE_BITS-1:0]            rel_left;
  logic                           in_attack;
  logic [AGE_BITS-1:0]            age_off;
  logic                           in_decay;

  logic                           smp_neg;
  logic [SAMPLE_BITS-1:0]         smp_mag;
  logic [LEVEL_BITS-1:0]          lvl_new;
  logic [PROD_BITS-1:0]           rnd;
  logic [RES_BITS-1:0]            mag_r;
  logic signed [SAMPLE_BITS-1:0]  scaled;

  adsr_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  adsr_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  adsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod),
    .divisor  (divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // The release counter saturates rather than wrapping. The release has ended once
  // the counter reaches the release length, which also covers a zero length.
  assign rel_inc   = (fade_age == '1) ? fade_age : fade_age + 1'b1;
  assign rel_done  = (rel_inc >= {1'b0, cfg.rel_ticks});
  assign rel_left  = {1'b0, cfg.rel_ticks} - rel_inc;

  // A zero-length attack or decay is skipped by these compares.
  assign in_attack = (note_age < {1'b0, cfg.atk_ticks});
  assign age_off   = note_age - {1'b0, cfg.atk_ticks};
  assign in_decay  = (age_off < {1'b0, cfg.dec_ticks});

  assign smp_neg   = smp[SAMPLE_BITS-1];
  assign smp_mag   = smp_neg ? (~smp + 1'b1) : smp;

  always_comb begin
    unique case (phase)
      PH_ATTACK:  divisor = cfg.atk_ticks;
      PH_DECAY:   divisor = cfg.dec_ticks;
      PH_RELEASE: divisor = cfg.rel_ticks;
      default:    divisor = cfg.rel_ticks;
    endcase
  end

  // On the decay ramp the divider yields the drop below unity; elsewhere the level itself.
  assign lvl_new = (phase == PH_DECAY) ? (UNITY - quotient) : quotient;

  // On a ramp the multiplier first forms the ramp numerator, then the sample times the level.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    if (state == ST_PLAN) begin
      if (req_off) begin
        if (!rel_done) begin
          mul_en = 1'b1;
          mul_a  = env_level;
          mul_b  = MUL_B_BITS'(rel_left);
        end
      end else if (in_attack) begin
        mul_en = 1'b1;
        mul_a  = UNITY;
        mul_b  = MUL_B_BITS'(note_age);
      end else if (in_decay) begin
        mul_en = 1'b1;
        mul_a  = UNITY - cfg.sus_level;
        mul_b  = MUL_B_BITS'(age_off);
      end else begin
        mul_en = 1'b1;
        mul_a  = cfg.sus_level;
        mul_b  = MUL_B_BITS'(smp_mag);
      end
    end else if (state == ST_DIV && div_stat.done) begin
      mul_en = 1'b1;
      mul_a  = lvl_new;
      mul_b  = MUL_B_BITS'(smp_mag);
    end
  end

  assign div_start = (state == ST_DSTART);

  // The product is of the magnitude; a negative sample rounds its magnitude up, which
  // floors the signed result towards minus infinity. The result is then saturated.
  assign rnd   = mul_prod + (smp_neg ? ROUND_ADD : '0);
  assign mag_r = rnd[PROD_BITS-1:FRAC_BITS];

  always_comb begin
    if (!smp_neg) begin
      scaled = (mag_r > POS_LIM) ? SAMPLE_MAX : mag_r[SAMPLE_BITS-1:0];
    end else begin
      scaled = (mag_r > NEG_LIM) ? SAMPLE_MIN : SAMPLE_BITS'(~mag_r[SAMPLE_BITS-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_ATTACK;
      note_age  <= '0;
      fade_age  <= '0;
      env_level <= '0;
      req_off   <= 1'b0;
      res_zero  <= 1'b0;
      wet_valid <= 1'b0;
    end else begin
      // A result taken while the next one is being loaded is replaced in the final state.
      if (wet_valid && wet.ready && (state != ST_FIN)) begin
        wet_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (dry.valid) begin
            smp     <= dry.sample_in;
            req_off <= dry.note_off;
            // A new note restarts both ages but keeps the level of the last note.
            if (dry.start_note) begin
              note_age <= '0;
              fade_age <= '0;
            end
            state <= ST_PLAN;
          end
        end
        ST_PLAN: begin
          res_zero <= req_off && rel_done;
          if (req_off) begin
            fade_age <= rel_inc;
            if (rel_done) begin
              state <= ST_FIN;
            end else begin
              phase <= PH_RELEASE;
              state <= ST_DSTART;
            end
          end else if (in_attack) begin
            phase    <= PH_ATTACK;
            note_age <= note_age + 1'b1;
            state    <= ST_DSTART;
          end else if (in_decay) begin
            phase    <= PH_DECAY;
            note_age <= note_age + 1'b1;
            state    <= ST_DSTART;
          end else begin
            env_level <= cfg.sus_level;
            state     <= ST_FIN;
          end
        end
        ST_DSTART: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            // The release gain scales the frozen level and does not replace it.
            if (phase != PH_RELEASE) begin
              env_level <= lvl_new;
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!wet_valid || wet.ready) begin
            wet_valid  <= 1'b1;
            wet_sample <= res_zero ? '0 : scaled;
            wet_alive  <= ~res_zero;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign dry.ready      = (state == ST_IDLE);
  assign wet.valid      = wet_valid;
  assign wet.sample_out = wet_sample;
  assign wet.alive      = wet_alive;

  a_accept_plans: assert property (@(posedge clk) disable iff (rst)
    (dry.valid && dry.ready) |=> (state == ST_PLAN))
    else $error("accepted request did not enter planning");

  a_level_unity: assert property (@(posedge clk) disable iff (rst)
    env_level <= UNITY)
    else $error("envelope level above unity");

  a_dead_is_silent: assert property (@(posedge clk) disable iff (rst)
    (wet.valid && !wet.alive) |-> (wet.sample_out == '0))
    else $error("finished release gave a non-zero sample");

endmodule

`default_nettype wire
